// ----- hdl/tccw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_pkg
// Shared types and constants for the text console cell writer.
// ----------------------------------------------------------------------------
package tccw_pkg;

  localparam logic [15:0] BLANK_CELL = 16'h0720;
  localparam logic [7:0]  CH_LF      = 8'h0A;
  localparam logic [7:0]  CH_SPACE   = 8'h20;

  // item modes carried on tuser
  localparam logic MODE_PUT  = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_EXEC  = 5'b00100,
    S_BLANK = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;    // latch the input item
    logic clear;     // write one blank cell of the reset clear pass
    logic put;       // put character, update cursor and row offset
    logic rd;        // issue the cell read
    logic blank;     // write one blank cell of the recycled row
    logic load_out;  // load the output register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic blank_last;
    logic need_scroll;
    logic mode;
    logic out_free;
  } dp_stat_t;

endpackage

// ----- hdl/tccw_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_ctrl
// Sequencer for the clear pass, put, read and row blanking steps.
// ----------------------------------------------------------------------------
module tccw_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  tccw_pkg::dp_stat_t stat,
  output tccw_pkg::dp_cmd_t  cmd
);

  tccw_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tccw_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == tccw_pkg::S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      tccw_pkg::S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) state_next = tccw_pkg::S_IDLE;
      end
      tccw_pkg::S_IDLE: begin
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = tccw_pkg::S_EXEC;
        end
      end
      tccw_pkg::S_EXEC: begin
        if (stat.mode) begin
          cmd.rd     = 1'b1;
          state_next = tccw_pkg::S_DONE;
        end else begin
          cmd.put = 1'b1;
          if (stat.need_scroll) begin
            state_next = tccw_pkg::S_BLANK;
          end else if (stat.out_free) begin
            // result goes straight to the output register
            cmd.load_out = 1'b1;
            state_next   = tccw_pkg::S_IDLE;
          end else begin
            state_next = tccw_pkg::S_DONE;
          end
        end
      end
      tccw_pkg::S_BLANK: begin
        cmd.blank = 1'b1;
        if (stat.blank_last) state_next = tccw_pkg::S_DONE;
      end
      tccw_pkg::S_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = tccw_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = tccw_pkg::S_CLEAR;
      end
    endcase
  end

endmodule

// ----- hdl/tccw_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tccw_dpath
// Frame store, cursor, circular row offset and output register.
// ----------------------------------------------------------------------------
module tccw_dpath #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic               clk,
  input  logic               rst,
  input  tccw_pkg::dp_cmd_t  cmd,
  output tccw_pkg::dp_stat_t stat,
  input  logic [31:0]        s_tdata,
  input  logic               s_tuser,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [31:0]        m_tdata
);

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int CELLS  = COLUMNS * ROWS;
  localparam int ADDR_W = $clog2(CELLS);

  // latched input item
  logic       in_mode;
  logic [7:0] in_char;
  logic [7:0] in_attr;
  logic [4:0] in_rrow;
  logic [6:0] in_rcol;

  logic [ROW_W-1:0]  cur_row;
  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  top;        // physical row holding logical row 0
  logic [ROW_W-1:0]  blank_row;
  logic [ADDR_W-1:0] cnt;
  logic              scr_flag;

  logic [15:0] mem [CELLS];
  logic [15:0] mem_q;

  logic        out_valid;
  logic [15:0] out_cell;
  logic [4:0]  out_row;
  logic [6:0]  out_col;
  logic        out_scr;

  logic              is_lf, is_pr;
  logic [COL_W:0]    col_inc;
  logic              col_wrap;
  logic [COL_W-1:0]  col_fin;
  logic [ROW_W:0]    row_inc;
  logic              need_scroll;
  logic [ROW_W-1:0]  row_fin;
  logic [ROW_W-1:0]  top_inc;
  logic              rd_ok;
  logic [ROW_W-1:0]  lrow;
  logic [ROW_W:0]    prow_sum;
  logic [ROW_W-1:0]  prow;
  logic [ROW_W-1:0]  row_addr;
  logic [COL_W-1:0]  col_addr;
  logic [ADDR_W-1:0] cell_addr;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [15:0]       wdata;
  logic              clear_last, blank_last, out_free;

  // cursor arithmetic; high bytes are negative as a signed char
  always_comb begin
    is_lf    = (in_char == tccw_pkg::CH_LF);
    is_pr    = !in_char[7] && (in_char >= tccw_pkg::CH_SPACE);
    col_inc  = {1'b0, cur_col} + (COL_W+1)'(is_pr);
    col_wrap = (col_inc == (COL_W+1)'(COLUMNS));
    col_fin  = (is_lf || col_wrap) ? '0 : col_inc[COL_W-1:0];
    row_inc  = {1'b0, cur_row} + (ROW_W+1)'(is_lf || col_wrap);
    need_scroll = (row_inc == (ROW_W+1)'(ROWS));
    row_fin  = need_scroll ? ROW_W'(ROWS - 1) : row_inc[ROW_W-1:0];
    top_inc  = (top == ROW_W'(ROWS - 1)) ? '0 : top + 1'b1;
  end

  // logical to physical row, then cell address
  always_comb begin
    rd_ok    = (8'(in_rrow) < 8'(ROWS)) && (9'(in_rcol) < 9'(COLUMNS));
    lrow     = cmd.rd ? ROW_W'(in_rrow) : cur_row;
    prow_sum = {1'b0, lrow} + {1'b0, top};
    prow     = (prow_sum >= (ROW_W+1)'(ROWS)) ?
               ROW_W'(prow_sum - (ROW_W+1)'(ROWS)) : prow_sum[ROW_W-1:0];
    row_addr = cmd.blank ? blank_row : prow;
    col_addr = cmd.blank ? cnt[COL_W-1:0] : (cmd.rd ? COL_W'(in_rcol) : cur_col);
    cell_addr = ADDR_W'(row_addr) * ADDR_W'(COLUMNS) + ADDR_W'(col_addr);
    we    = cmd.clear || cmd.blank || (cmd.put && is_pr);
    waddr = cmd.clear ? cnt : cell_addr;
    wdata = cmd.put ? {in_attr, in_char} : tccw_pkg::BLANK_CELL;
  end

  assign clear_last = (cnt == ADDR_W'(CELLS - 1));
  assign blank_last = (cnt == ADDR_W'(COLUMNS - 1));
  assign out_free   = !out_valid || m_tready;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (cmd.rd) mem_q <= mem[cell_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      in_mode <= s_tuser;
      in_char <= s_tdata[7:0];
      in_attr <= s_tdata[15:8];
      in_rrow <= s_tdata[20:16];
      in_rcol <= s_tdata[27:21];
    end
    if (cmd.put) blank_row <= top;
    if (cmd.load_out) begin
      out_cell <= (in_mode && rd_ok) ? mem_q : 16'h0000;
      out_row  <= cmd.put ? 5'(row_fin) : 5'(cur_row);
      out_col  <= cmd.put ? 7'(col_fin) : 7'(cur_col);
      out_scr  <= cmd.put ? need_scroll : scr_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_row   <= '0;
      cur_col   <= '0;
      top       <= '0;
      cnt       <= '0;
      scr_flag  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.accept) scr_flag <= 1'b0;
      if (cmd.put) begin
        cur_row  <= row_fin;
        cur_col  <= col_fin;
        scr_flag <= need_scroll;
        if (need_scroll) top <= top_inc;
      end
      if (cmd.clear) begin
        cnt <= clear_last ? '0 : cnt + 1'b1;
      end else if (cmd.blank) begin
        cnt <= blank_last ? '0 : cnt + 1'b1;
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign stat.clear_last  = clear_last;
  assign stat.blank_last  = blank_last;
  assign stat.need_scroll = need_scroll;
  assign stat.mode        = in_mode;
  assign stat.out_free    = out_free;

  assign m_tvalid = out_valid;
  assign m_tdata  = {3'b000, out_scr, out_col, out_row, out_cell};

endmodule

// ----- hdl/text_console_cell_writer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cell_writer
// Character cell frame with write cursor, line feed, wrap and scroll.
// ----------------------------------------------------------------------------
// put item: cell written and result loaded in the execute state if the output is free;
//   read item: read via the registered frame store read port, result loaded in done
// a put that scrolls blanks the recycled row one cell a cycle (COLUMNS cells), then
//   the result is loaded; rows live in a circular store
// one item in work at a time; a result held by m_tready stalls the next item
// reset: synchronous, then a clear pass writes all COLUMNS*ROWS cells (2000) blank
module text_console_cell_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // char_code[7:0], attribute[15:8],
                                 // read_row[20:16], read_col[27:21], zero
  input  logic        s_tuser,   // mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // cell_value[15:0], cursor_row[20:16],
                                 // cursor_col[27:21], scrolled[28], zero
);

  // blank cells are written one per cycle before the first item is taken

  tccw_pkg::dp_cmd_t  cmd;
  tccw_pkg::dp_stat_t stat;

  tccw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tccw_dpath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
